[hdl/assert_macros.svh]
// Assertion macros shared by the epoch-to-calendar RTL.
// Depends on nothing; each asserting module includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hdl/etc_pkg.sv]
// Shared types, constants and helper functions for the epoch-to-calendar block.
// Depends on nothing; used by every module of the block.
package etc_pkg;

   // Reciprocal constants for exact division by 15, 3 and 7 over the used ranges.
   localparam logic [31:0] MAGIC_DIV15 = 32'h8888_8889;  // shift right by 35
   localparam logic [31:0] MAGIC_DIV3  = 32'hAAAA_AAAB;  // shift right by 33
   localparam logic [31:0] MAGIC_DIV7  = 32'd149797;     // shift right by 20

   // Calendar constants.
   localparam logic [7:0]  EPOCH_YEAR_OFFSET = 8'd70;    // 1970 minus 1900
   localparam logic [3:0]  LAST_MONTH        = 4'd11;
   localparam logic [16:0] EPOCH_WEEKDAY     = 17'd4;    // the epoch fell on a Thursday
   localparam logic [8:0]  DAYS_COMMON_YEAR  = 9'd365;
   localparam logic [8:0]  DAYS_LEAP_YEAR    = 9'd366;
   localparam logic [3:0]  MONTH_FEBRUARY    = 4'd1;

   // One word handed from the front to the back through the queue.
   typedef struct packed {
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [15:0] days;
   } front_word_type;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_SEC,
      FR_MIN,
      FR_HOUR,
      FR_DAY,
      FR_WDAY,
      FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_YEAR,
      BK_MONTH,
      BK_DONE
   } back_state_type;

   // Leap rule for a year given as an offset from 1900. Within 1900..2155 the
   // only century years are 1900 and 2100 (common) and 2000 (leap).
   function automatic logic is_leap(input logic [7:0] year_offset);
      logic div4;
      div4 = (year_offset[1:0] == 2'd0);
      return div4 && (year_offset != 8'd0) && (year_offset != 8'd200);
   endfunction

   // Length of a common-year month, January being zero.
   function automatic logic [4:0] common_month_length(input logic [3:0] month);
      logic [4:0] len;
      case (month)
         4'd0:    len = 5'd31;
         4'd1:    len = 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

[hdl/etc_front.sv]
// Front part: accepts an epoch count and splits it into time of day, weekday and days.
// Depends on etc_pkg and assert_macros.svh; feeds etc_queue.
`include "assert_macros.svh"

module etc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [31:0]             req_epoch_seconds,
   output logic                    q_push,
   output etc_pkg::front_word_type q_word,
   input  logic                    q_full
);

   etc_pkg::front_state_type state_ff, state_in;

   logic [31:0] secs_ff;
   logic [26:0] mins_ff;
   logic [20:0] hours_ff;
   logic [15:0] days_ff;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [2:0]  wday_ff, wday_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;

   // Quotients read out of the shared product register.
   logic [26:0] mins_w;
   logic [20:0] hours_w;
   logic [15:0] days_w;
   logic [14:0] weeks_w;
   logic [16:0] days_shift;

   assign mins_w     = prod_ff[61:35];
   assign hours_w    = prod_ff[55:35];
   assign days_w     = prod_ff[48:33];
   assign weeks_w    = prod_ff[34:20];
   assign days_shift = {1'b0, days_ff} + etc_pkg::EPOCH_WEEKDAY;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         etc_pkg::FR_IDLE: if (push) state_in = etc_pkg::FR_SEC;
         etc_pkg::FR_SEC:  state_in = etc_pkg::FR_MIN;
         etc_pkg::FR_MIN:  state_in = etc_pkg::FR_HOUR;
         etc_pkg::FR_HOUR: state_in = etc_pkg::FR_DAY;
         etc_pkg::FR_DAY:  state_in = etc_pkg::FR_WDAY;
         etc_pkg::FR_WDAY: state_in = etc_pkg::FR_PUSH;
         etc_pkg::FR_PUSH: if (!q_full) state_in = etc_pkg::FR_IDLE;
         default:          state_in = etc_pkg::FR_IDLE;
      endcase
   end

   // Shared multiplier operands and the remainders taken after each quotient.
   always_comb begin
      mul_a   = 32'd0;
      mul_b   = 32'd0;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;
      wday_in = wday_ff;
      q_push  = 1'b0;
      case (state_ff)
         etc_pkg::FR_SEC: begin
            mul_a = {2'b00, secs_ff[31:2]};
            mul_b = etc_pkg::MAGIC_DIV15;
         end
         etc_pkg::FR_MIN: begin
            mul_a  = 32'(mins_w[26:2]);
            mul_b  = etc_pkg::MAGIC_DIV15;
            sec_in = 6'(secs_ff - 32'(mins_w) * 32'd60);
         end
         etc_pkg::FR_HOUR: begin
            mul_a  = 32'(hours_w[20:3]);
            mul_b  = etc_pkg::MAGIC_DIV3;
            min_in = 6'(mins_ff - 27'(hours_w) * 27'd60);
         end
         etc_pkg::FR_DAY: begin
            mul_a   = 32'({1'b0, days_w} + etc_pkg::EPOCH_WEEKDAY);
            mul_b   = etc_pkg::MAGIC_DIV7;
            hour_in = 5'(hours_ff - 21'(days_w) * 21'd24);
         end
         etc_pkg::FR_WDAY: begin
            wday_in = 3'(days_shift - 17'(weeks_w) * 17'd7);
         end
         etc_pkg::FR_PUSH: q_push = !q_full;
         default: begin
         end
      endcase
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);
   assign full    = (state_ff != etc_pkg::FR_IDLE);

   assign q_word.second  = sec_ff;
   assign q_word.minute  = min_ff;
   assign q_word.hour    = hour_ff;
   assign q_word.weekday = wday_ff;
   assign q_word.days    = days_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= etc_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Datapath registers; each quotient is captured in the cycle after its product.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sec_ff  <= sec_in;
      min_ff  <= min_in;
      hour_ff <= hour_in;
      wday_ff <= wday_in;
      if (state_ff == etc_pkg::FR_IDLE && push) secs_ff <= req_epoch_seconds;
      if (state_ff == etc_pkg::FR_MIN) mins_ff <= mins_w;
      if (state_ff == etc_pkg::FR_HOUR) hours_ff <= hours_w;
      if (state_ff == etc_pkg::FR_DAY) days_ff <= days_w;
   end

   // An accepted word keeps the front busy in the following cycle.
   `ASSERT_NEXT(a_front_busy_after_accept, clock, reset, push && !full, full)
   // A word leaves only from the last step of the sequence.
   `ASSERT_IMPLIES(a_front_push_state, clock, reset, q_push,
                   state_ff == etc_pkg::FR_PUSH && !q_full)
   // The remainders stay inside their ranges when the word is handed over.
   `ASSERT_IMPLIES(a_front_ranges, clock, reset, q_push,
                   sec_ff < 6'd60 && min_ff < 6'd60 && hour_ff < 5'd24 && wday_ff < 3'd7)

endmodule

[hdl/etc_queue.sv]
// Short register queue that decouples the front part from the back part.
// Depends on etc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module etc_queue #(
   parameter int DEPTH = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  etc_pkg::front_word_type push_word,
   output logic                    full,
   input  logic                    pop,
   output etc_pkg::front_word_type pop_word,
   output logic                    empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

   etc_pkg::front_word_type word_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == CW'(0));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = word_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the last slot.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? PW'(0) : wr_ptr_ff + PW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? PW'(0) : rd_ptr_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) word_ff[wr_ptr_ff] <= push_word;
   end

   // The fill count never exceeds the depth.
   `ASSERT_IMPLIES(a_queue_count, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   // Pointers agree with the fill count when the queue is empty or full.
   `ASSERT_IMPLIES(a_queue_ptrs, clock, reset, empty || full, wr_ptr_ff == rd_ptr_ff)
   // A push without a pop leaves at least one word stored.
   `ASSERT_NEXT(a_queue_push_fill, clock, reset, do_push && !do_pop, count_ff != CW'(0))

endmodule

[hdl/etc_back.sv]
// Back part: walks years and months off the day count and holds the finished word.
// Depends on etc_pkg and assert_macros.svh; fed by etc_queue.
`include "assert_macros.svh"

module etc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  etc_pkg::front_word_type q_word,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output logic [5:0]              rsp_second,
   output logic [5:0]              rsp_minute,
   output logic [4:0]              rsp_hour,
   output logic [2:0]              rsp_weekday,
   output logic [7:0]              rsp_years_since_1900,
   output logic [8:0]              rsp_day_of_year,
   output logic [3:0]              rsp_month_index,
   output logic [4:0]              rsp_day_of_month
);

   etc_pkg::back_state_type state_ff, state_in;

   etc_pkg::front_word_type work_ff;
   logic [15:0] days_ff, days_in;
   logic [7:0]  year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [8:0]  yday_ff;
   logic        leap_ff;
   logic        out_valid_ff, out_valid_in;
   logic        load_out;

   logic        leap_now;
   logic [8:0]  year_len;
   logic [4:0]  month_len;
   logic        year_fits;
   logic        month_fits;

   assign leap_now   = etc_pkg::is_leap(year_ff);
   assign year_len   = leap_now ? etc_pkg::DAYS_LEAP_YEAR : etc_pkg::DAYS_COMMON_YEAR;
   assign month_len  = etc_pkg::common_month_length(month_ff) +
                       5'((month_ff == etc_pkg::MONTH_FEBRUARY) && leap_ff);
   assign year_fits  = (days_ff < 16'(year_len));
   assign month_fits = (days_ff < 16'(month_len)) || (month_ff == etc_pkg::LAST_MONTH);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         etc_pkg::BK_IDLE:  if (!q_empty) state_in = etc_pkg::BK_YEAR;
         etc_pkg::BK_YEAR:  if (year_fits) state_in = etc_pkg::BK_MONTH;
         etc_pkg::BK_MONTH: if (month_fits) state_in = etc_pkg::BK_DONE;
         etc_pkg::BK_DONE:  if (!out_valid_ff || pop) state_in = etc_pkg::BK_IDLE;
         default:           state_in = etc_pkg::BK_IDLE;
      endcase
   end

   // Walk datapath and handshake outputs.
   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      days_in  = days_ff;
      year_in  = year_ff;
      month_in = month_ff;
      case (state_ff)
         etc_pkg::BK_IDLE: begin
            q_pop    = !q_empty;
            days_in  = q_word.days;
            year_in  = etc_pkg::EPOCH_YEAR_OFFSET;
            month_in = 4'd0;
         end
         etc_pkg::BK_YEAR: begin
            if (!year_fits) begin
               days_in = days_ff - 16'(year_len);
               year_in = year_ff + 8'd1;
            end
         end
         etc_pkg::BK_MONTH: begin
            if (!month_fits) begin
               days_in  = days_ff - 16'(month_len);
               month_in = month_ff + 4'd1;
            end
         end
         etc_pkg::BK_DONE: load_out = !out_valid_ff || pop;
         default: begin
         end
      endcase
   end

   assign out_valid_in = load_out || (out_valid_ff && !pop);
   assign empty        = !out_valid_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= etc_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Working registers and the result word.
   always_ff @(posedge clock) begin
      days_ff  <= days_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      if (q_pop) work_ff <= q_word;
      if (state_ff == etc_pkg::BK_YEAR && year_fits) begin
         yday_ff <= days_ff[8:0];
         leap_ff <= leap_now;
      end
      if (load_out) begin
         rsp_second           <= work_ff.second;
         rsp_minute           <= work_ff.minute;
         rsp_hour             <= work_ff.hour;
         rsp_weekday          <= work_ff.weekday;
         rsp_years_since_1900 <= year_ff;
         rsp_day_of_year      <= yday_ff;
         rsp_month_index      <= month_ff;
         rsp_day_of_month     <= 5'(days_ff + 16'd1);
      end
   end

   // The largest input lands in 2106, so the year walk never passes it.
   `ASSERT_IMPLIES(a_back_year_bound, clock, reset, state_ff == etc_pkg::BK_YEAR,
                   year_ff <= 8'd206)
   // The month walk only starts with less than a year of days left.
   `ASSERT_IMPLIES(a_back_month_bound, clock, reset, state_ff == etc_pkg::BK_MONTH,
                   month_ff <= etc_pkg::LAST_MONTH && days_ff < 16'd366)
   // A finished word is never overwritten while it waits.
   `ASSERT_IMPLIES(a_back_no_overwrite, clock, reset, load_out, !out_valid_ff || pop)

endmodule

[hdl/epoch_seconds_to_calendar_core.sv]
// Top level of the epoch-seconds to Gregorian calendar converter.
// Depends on etc_pkg, etc_front, etc_queue and etc_back.
//
//   Channel   Handshake        Direction  Payload
//   request   push / full      in         req_epoch_seconds
//   response  pop / empty      out        rsp_second .. rsp_day_of_month
//
// Front: one word at a time, through the accepting step, four products on one shared
// 32x32 multiplier, a weekday remainder step and the hand-off into the queue.
// Back: a year walk and a month walk, one subtraction per cycle for each year past 1970
// and each month past January; the longest walk is for a date late in 2105.
// Reset is synchronous and clears only control state; no clearing pass is needed.
// The front stalls on a full queue, the back stalls while a finished word waits.
module epoch_seconds_to_calendar_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [31:0] req_epoch_seconds,
   output logic        empty,
   input  logic        pop,
   output logic [5:0]  rsp_second,
   output logic [5:0]  rsp_minute,
   output logic [4:0]  rsp_hour,
   output logic [2:0]  rsp_weekday,
   output logic [7:0]  rsp_years_since_1900,
   output logic [8:0]  rsp_day_of_year,
   output logic [3:0]  rsp_month_index,
   output logic [4:0]  rsp_day_of_month
);

   etc_pkg::front_word_type fq_word, qb_word;
   logic fq_push, fq_full;
   logic qb_pop, qb_empty;

   // Time-of-day and day-count split.
   etc_front u_front (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_epoch_seconds (req_epoch_seconds),
      .q_push            (fq_push),
      .q_word            (fq_word),
      .q_full            (fq_full)
   );

   // Decoupling queue.
   etc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_word (fq_word),
      .full      (fq_full),
      .pop       (qb_pop),
      .pop_word  (qb_word),
      .empty     (qb_empty)
   );

   // Year and month walk with the result register.
   etc_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_empty              (qb_empty),
      .q_word               (qb_word),
      .q_pop                (qb_pop),
      .empty                (empty),
      .pop                  (pop),
      .rsp_second           (rsp_second),
      .rsp_minute           (rsp_minute),
      .rsp_hour             (rsp_hour),
      .rsp_weekday          (rsp_weekday),
      .rsp_years_since_1900 (rsp_years_since_1900),
      .rsp_day_of_year      (rsp_day_of_year),
      .rsp_month_index      (rsp_month_index),
      .rsp_day_of_month     (rsp_day_of_month)
   );

endmodule

[test/epoch_seconds_to_calendar_checker.sv]
// Checker for the epoch-seconds to calendar converter: watches both channels,
// predicts each calendar word from the accepted seconds and compares field by field.
// Depends on nothing but the port signals of epoch_seconds_to_calendar_core.
module epoch_seconds_to_calendar_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        full,
   input  logic [31:0] req_epoch_seconds,
   input  logic        empty,
   input  logic        pop,
   input  logic [5:0]  rsp_second,
   input  logic [5:0]  rsp_minute,
   input  logic [4:0]  rsp_hour,
   input  logic [2:0]  rsp_weekday,
   input  logic [7:0]  rsp_years_since_1900,
   input  logic [8:0]  rsp_day_of_year,
   input  logic [3:0]  rsp_month_index,
   input  logic [4:0]  rsp_day_of_month,
   output int          error_count,
   output int          pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FIRST_YEAR = 1970;
   localparam int unsigned YEAR_BIAS = 1900;
   localparam int unsigned SHOWN_MISMATCHES = 10;
   localparam int unsigned COMMON_MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30,
                                                      31, 31, 30, 31, 30, 31};

   // One expected calendar word, with the seconds that produced it.
   typedef struct packed {
      logic [31:0] seconds;
      logic [5:0]  second;
      logic [5:0]  minute;
      logic [4:0]  hour;
      logic [2:0]  weekday;
      logic [7:0]  years_since_1900;
      logic [8:0]  day_of_year;
      logic [3:0]  month_index;
      logic [4:0]  day_of_month;
   } calendar_word_type;

   calendar_word_type expected_dates[$];
   int mismatches = 0;
   int outstanding = 0;

   assign error_count = mismatches;
   assign pending_words = outstanding;

   // Gregorian leap rule on the full year number.
   function automatic bit is_gregorian_leap(input int unsigned year);
      return ((year % 4) == 0 && (year % 100) != 0) || ((year % 400) == 0);
   endfunction

   // Breaks a seconds count down into time of day, weekday and calendar date.
   function automatic calendar_word_type calendar_of_seconds(input logic [31:0] secs);
      calendar_word_type w;
      int unsigned total_minutes;
      int unsigned total_hours;
      int unsigned days_left;
      int unsigned year;
      int unsigned month;
      int unsigned month_len;
      bit leap;
      w.seconds = secs;
      w.second = 6'(secs % 60);
      total_minutes = secs / 60;
      w.minute = 6'(total_minutes % 60);
      total_hours = total_minutes / 60;
      w.hour = 5'(total_hours % 24);
      days_left = total_hours / 24;
      // The first day counted was a Thursday.
      w.weekday = 3'((days_left + 4) % 7);
      year = FIRST_YEAR;
      while (days_left >= (is_gregorian_leap(year) ? 366 : 365)) begin
         days_left -= is_gregorian_leap(year) ? 366 : 365;
         year++;
      end
      w.years_since_1900 = 8'(year - YEAR_BIAS);
      w.day_of_year = 9'(days_left);
      leap = is_gregorian_leap(year);
      month = 0;
      while (month < 11) begin
         month_len = COMMON_MONTH_DAYS[month] + ((month == 1 && leap) ? 1 : 0);
         if (days_left < month_len) break;
         days_left -= month_len;
         month++;
      end
      w.month_index = 4'(month);
      w.day_of_month = 5'(days_left + 1);
      return w;
   endfunction

   task automatic check_field(input string label, input int unsigned want,
                              input int unsigned got, input logic [31:0] secs);
      if (want != got) begin
         mismatches++;
         if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t: %s wrong for %0d seconds: expected %0d, got %0d",
                     $realtime, label, secs, want, got);
      end
   endtask

   // Predict on every accepted input word, compare on every accepted result word.
   always @(posedge clock) begin
      calendar_word_type want;
      if (!reset) begin
         if (push && !full) begin
            expected_dates.push_back(calendar_of_seconds(req_epoch_seconds));
            outstanding++;
         end
         if (pop && !empty) begin
            if (expected_dates.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOWN_MISMATCHES)
                  $display("%0t: result word arrived with nothing expected", $realtime);
            end else begin
               want = expected_dates.pop_front();
               outstanding--;
               check_field("second", want.second, rsp_second, want.seconds);
               check_field("minute", want.minute, rsp_minute, want.seconds);
               check_field("hour", want.hour, rsp_hour, want.seconds);
               check_field("weekday", want.weekday, rsp_weekday, want.seconds);
               check_field("years_since_1900", want.years_since_1900,
                           rsp_years_since_1900, want.seconds);
               check_field("day_of_year", want.day_of_year, rsp_day_of_year,
                           want.seconds);
               check_field("month_index", want.month_index, rsp_month_index,
                           want.seconds);
               check_field("day_of_month", want.day_of_month, rsp_day_of_month,
                           want.seconds);
            end
         end
      end
   end

endmodule

[test/epoch_seconds_to_calendar_core_tb.sv]
// Testbench top for epoch_seconds_to_calendar_core: drives seconds words and pops
// calendar words with random idling and stalls. Depends on the core and on
// epoch_seconds_to_calendar_checker, which predicts and compares.
module epoch_seconds_to_calendar_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1728;
   localparam int SENDER_STEADY_FIRST = 300;
   localparam int SENDER_STEADY_LAST = 700;
   localparam int SENDER_DRAIN_AT = 1200;
   localparam int RECEIVER_HOLD_AT = 30000;
   localparam int RECEIVER_HOLD_CYCLES = 3000;
   localparam int RECEIVER_STEADY_FIRST = 60000;
   localparam int RECEIVER_STEADY_LAST = 100000;
   localparam int TAIL_CYCLES = 200;
   localparam int STALL_LIMIT = 20000;
   localparam int unsigned SECONDS_PER_DAY = 86400;
   localparam int unsigned LAST_FULL_DAY = 49709;

   // Calendar corners: field extremes, year and month ends, leap and century years.
   localparam logic [31:0] CORNER_SECONDS [22] = '{
      32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000, 32'd63071999, 32'd68169600, 32'd94521600,
      32'd951782400, 32'd978220800, 32'd4107456000, 32'd4107542400,
      32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555, 32'd4294944000
   };

   logic        clock;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [31:0] req_epoch_seconds = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [5:0]  rsp_second;
   logic [5:0]  rsp_minute;
   logic [4:0]  rsp_hour;
   logic [2:0]  rsp_weekday;
   logic [7:0]  rsp_years_since_1900;
   logic [8:0]  rsp_day_of_year;
   logic [3:0]  rsp_month_index;
   logic [4:0]  rsp_day_of_month;
   int          error_count;
   int          pending_words;
   bit          sender_steady = 1'b0;

   epoch_seconds_to_calendar_core dut (.*);

   epoch_seconds_to_calendar_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offers one seconds word, idling first at random, and returns once it is taken.
   task automatic offer_seconds(input logic [31:0] secs);
      while (!sender_steady && $urandom_range(99) < 20) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push <= 1'b1;
      req_epoch_seconds <= secs;
      do @(posedge clock); while (full);
      @(negedge clock);
   endtask

   // Mostly uniform words, plus day edges, early years that keep the walk short and words near the top.
   function automatic logic [31:0] pick_seconds();
      int unsigned kind;
      int unsigned day;
      kind = $urandom_range(99);
      day = $urandom_range(LAST_FULL_DAY);
      if (kind < 60)
         return $urandom;
      else if (kind < 80)
         return day * SECONDS_PER_DAY + ($urandom_range(1) ? SECONDS_PER_DAY - 1 : 0);
      else if (kind < 92)
         return $urandom_range(400000000);
      else
         return 32'hFFF0_0000 | ($urandom & 32'h000F_FFFF);
   endfunction

   // Sender: corners first, then random words with one full drain in the middle.
   initial begin : sender
      int n;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (CORNER_SECONDS[i]) offer_seconds(CORNER_SECONDS[i]);
      for (n = 0; n < RANDOM_WORDS; n++) begin
         sender_steady = (n >= SENDER_STEADY_FIRST && n < SENDER_STEADY_LAST);
         if (n == SENDER_DRAIN_AT) begin
            push <= 1'b0;
            do @(negedge clock); while (pending_words != 0);
         end
         offer_seconds(pick_seconds());
      end
      push <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && pending_words == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Receiver: random pops, one long hold-off so the block backs up, one steady stretch.
   initial begin : receiver
      int cycle_count;
      cycle_count = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         cycle_count++;
         if (cycle_count == RECEIVER_HOLD_AT) begin
            pop <= 1'b0;
            repeat (RECEIVER_HOLD_CYCLES) @(negedge clock);
         end else begin
            pop <= (cycle_count >= RECEIVER_STEADY_FIRST &&
                    cycle_count < RECEIVER_STEADY_LAST) || $urandom_range(99) >= 20;
            @(negedge clock);
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((push && !full) || (pop && !empty))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/etc_pkg.sv
hdl/etc_front.sv
hdl/etc_queue.sv
hdl/etc_back.sv
hdl/epoch_seconds_to_calendar_core.sv
test/epoch_seconds_to_calendar_checker.sv
test/epoch_seconds_to_calendar_core_tb.sv
